@@ rtl/core/cbe_pkg.sv @@
// Shared constants for the cubic Bezier easing core.
// Holds config register indexes and the sequencer state codes.
// No dependencies.
package cbe_pkg;

  // Config register indexes
  localparam logic [7:0] REG_X1 = 8'd0;
  localparam logic [7:0] REG_Y1 = 8'd1;
  localparam logic [7:0] REG_X2 = 8'd2;
  localparam logic [7:0] REG_Y2 = 8'd3;

  // Sequencer states
  localparam int unsigned STW = 4;
  localparam logic [STW-1:0] ST_IDLE  = 4'd0;
  localparam logic [STW-1:0] ST_POLY  = 4'd1;
  localparam logic [STW-1:0] ST_PCHK  = 4'd2;
  localparam logic [STW-1:0] ST_DPOLY = 4'd3;
  localparam logic [STW-1:0] ST_DCHK  = 4'd4;
  localparam logic [STW-1:0] ST_DIV   = 4'd5;
  localparam logic [STW-1:0] ST_UPD   = 4'd6;
  localparam logic [STW-1:0] ST_BCHK  = 4'd7;
  localparam logic [STW-1:0] ST_OUT   = 4'd8;

endpackage

@@ rtl/core/cubic_bezier_easing.sv @@
// Cubic Bezier timing curve evaluator, fixed point, one shared multiplier.
// Depends on cbe_pkg (register indexes, state codes).
//
// Steps: progress at 0 or 1.0 passes straight through; otherwise each Newton step
//   runs x poly, check, slope, check, restoring divide (may be skipped), update;
//   each bisection step a check, x poly and check; then the y poly and output.
// Throughput: one word at a time; in_ready_o is high only when idle.
//   Polynomials use the shared multiplier in Horner form; the divider is bit-serial.
// Reset: async active low; clears sequencer, output valid, and loads
//   x1=0, y1=0, x2=1.0, y2=1.0.
module cubic_bezier_easing #(
  parameter int FRAC_BITS     = 16,
  parameter int NEWTON_STEPS  = 8,
  parameter int TOLERANCE_LSB = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [7:0]                  cfg_index_i,
  input  logic [FRAC_BITS+2:0]        cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [FRAC_BITS:0]          progress_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [FRAC_BITS+2:0] eased_o
);
  import cbe_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int XW  = F + 1;
  localparam int YW  = F + 3;
  localparam int CW  = F + 8;    // polynomial coefficients
  localparam int AW  = F + 10;   // Horner accumulator
  localparam int SW  = F + 2;    // curve parameter, signed
  localparam int QB  = F + 2;    // quotient bits before saturation
  localparam int RW  = AW + F + 2;
  localparam int CNW = $clog2(QB);
  localparam int NW  = $clog2(NEWTON_STEPS + 1);

  localparam logic [XW-1:0]        ONE_X  = XW'(1) << F;
  localparam logic signed [CW-1:0] ONE_C  = CW'(1) <<< F;
  localparam logic signed [AW-1:0] YMIN   = -(AW'(2) <<< F);
  localparam logic signed [AW-1:0] YMAX   = AW'(3) <<< F;
  localparam logic [AW-1:0]        TOL    = AW'(TOLERANCE_LSB);
  localparam logic [XW:0]          TOL_X  = (XW+1)'(TOLERANCE_LSB);
  localparam logic [NW-1:0]        NLAST  = NW'(NEWTON_STEPS - 1);

  // Config registers
  logic [XW-1:0] x1_q, x2_q;
  logic [YW-1:0] y1_q, y2_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q <= '0;
      y1_q <= '0;
      x2_q <= ONE_X;
      y2_q <= YW'(ONE_X);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_X1:  x1_q <= cfg_data_i[XW-1:0];
        REG_Y1:  y1_q <= cfg_data_i;
        REG_X2:  x2_q <= cfg_data_i[XW-1:0];
        REG_Y2:  y2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Coefficients from the control points; x controls limited to 1.0
  logic [XW-1:0]        x1c, x2c, t_in;
  logic signed [CW-1:0] x1s, x2s, y1s, y2s;
  logic signed [CW-1:0] cx, bx, ax, cy, by, ay;

  always_comb begin
    x1c  = (x1_q > ONE_X) ? ONE_X : x1_q;
    x2c  = (x2_q > ONE_X) ? ONE_X : x2_q;
    t_in = (progress_i > ONE_X) ? ONE_X : progress_i;
    x1s  = CW'(x1c);
    x2s  = CW'(x2c);
    y1s  = {{(CW-YW){y1_q[YW-1]}}, y1_q};
    y2s  = {{(CW-YW){y2_q[YW-1]}}, y2_q};
    cx   = x1s + x1s + x1s;
    bx   = (x2s - x1s) + (x2s - x1s) + (x2s - x1s) - cx;
    ax   = ONE_C - cx - bx;
    cy   = y1s + y1s + y1s;
    by   = (y2s - y1s) + (y2s - y1s) + (y2s - y1s) - cy;
    ay   = ONE_C - cy - by;
  end

  // Datapath and sequencer registers
  logic [STW-1:0]        st_q, st_d;
  logic signed [CW-1:0]  ax_q, bx_q, cx_q, ay_q, by_q, cy_q, a3_q, b2_q;
  logic signed [CW-1:0]  ax_d, bx_d, cx_d, ay_d, by_d, cy_d, a3_d, b2_d;
  logic [XW-1:0]         t_q, t_d, lo_q, lo_d, hi_q, hi_d;
  logic signed [SW-1:0]  s_q, s_d;
  logic signed [AW-1:0]  acc_q, acc_d, err_q, err_d;
  logic [1:0]            ph_q, ph_d;
  logic                  ysel_q, ysel_d, bis_q, bis_d, qneg_q, qneg_d;
  logic [NW-1:0]         ni_q, ni_d;
  logic [RW-1:0]         rem_q, rem_d, dsh_q, dsh_d;
  logic [QB-1:0]         qm_q, qm_d;
  logic [CNW-1:0]        cnt_q, cnt_d;
  logic signed [YW-1:0]  eased_q, eased_d;

  // Shared multiplier: round-to-nearest Q.F product against s
  logic signed [CW-1:0]    p2, p1, p0;
  logic signed [AW-1:0]    mul_a, mul_r;
  logic signed [AW+SW-1:0] prod, rnd;

  always_comb begin
    p2 = ysel_q ? ay_q : ax_q;
    p1 = ysel_q ? by_q : bx_q;
    p0 = ysel_q ? cy_q : cx_q;
    if (st_q == ST_DPOLY) begin
      mul_a = (ph_q == 2'd0) ? AW'(a3_q) : acc_q + AW'(b2_q);
    end else begin
      unique case (ph_q)
        2'd0:    mul_a = AW'(p2);
        2'd1:    mul_a = acc_q + AW'(p1);
        default: mul_a = acc_q + AW'(p0);
      endcase
    end
    prod  = mul_a * (AW+SW)'(s_q);
    rnd   = prod + (AW+SW)'(1 <<< (F-1));
    mul_r = rnd[AW+F-1:F];
  end

  // Helpers for the check states
  logic signed [AW-1:0] diff, dval;
  logic [AW-1:0]        adiff, adval;
  logic [AW+1:0]        ad4;
  logic [XW:0]          span, mid;
  logic [XW-1:0]        nlo, nhi;
  logic signed [QB:0]   qs;
  logic signed [QB+1:0] snew;

  always_comb begin
    diff  = acc_q - AW'(t_q);
    adiff = diff[AW-1] ? AW'(-diff) : AW'(diff);
    dval  = acc_q + AW'(cx_q);
    adval = dval[AW-1] ? AW'(-dval) : AW'(dval);
    ad4   = {adval, 2'b00};
    span  = {1'b0, hi_q} - {1'b0, lo_q};
    // x(s) below t: raise the low end, else lower the high end
    nlo   = diff[AW-1] ? s_q[XW-1:0] : lo_q;
    nhi   = diff[AW-1] ? hi_q : s_q[XW-1:0];
    mid   = {1'b0, nlo} + {1'b0, nhi};
    qs    = qneg_q ? -$signed({1'b0, qm_q}) : $signed({1'b0, qm_q});
    snew  = (QB+2)'(s_q) - (QB+2)'(qs);
  end

  always_comb begin
    st_d = st_q;
    ax_d = ax_q; bx_d = bx_q; cx_d = cx_q; ay_d = ay_q; by_d = by_q; cy_d = cy_q;
    a3_d = a3_q; b2_d = b2_q;
    t_d = t_q; lo_d = lo_q; hi_d = hi_q; s_d = s_q;
    acc_d = acc_q; err_d = err_q; ph_d = ph_q;
    ysel_d = ysel_q; bis_d = bis_q; qneg_d = qneg_q; ni_d = ni_q;
    rem_d = rem_q; dsh_d = dsh_q; qm_d = qm_q; cnt_d = cnt_q;
    eased_d = eased_q;
    unique case (st_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ax_d = ax; bx_d = bx; cx_d = cx; ay_d = ay; by_d = by; cy_d = cy;
          a3_d = ax + ax + ax;
          b2_d = bx + bx;
          t_d  = t_in;
          s_d  = SW'(t_in);
          ph_d = 2'd0; ysel_d = 1'b0; bis_d = 1'b0; ni_d = '0;
          if (t_in == '0 || t_in == ONE_X) begin
            // Ends pass through without solving
            eased_d = YW'(t_in);
            st_d    = ST_OUT;
          end else begin
            st_d = ST_POLY;
          end
        end
      end
      ST_POLY: begin
        acc_d = mul_r;
        ph_d  = ph_q + 2'd1;
        if (ph_q == 2'd2) begin
          ph_d = 2'd0;
          st_d = ST_PCHK;
        end
      end
      ST_PCHK: begin
        if (ysel_q) begin
          if (acc_q < YMIN)      eased_d = YW'(YMIN);
          else if (acc_q > YMAX) eased_d = YW'(YMAX);
          else                   eased_d = acc_q[YW-1:0];
          st_d = ST_OUT;
        end else if (adiff <= TOL) begin
          ysel_d = 1'b1;
          st_d   = ST_POLY;
        end else if (!bis_q) begin
          err_d = diff;
          st_d  = ST_DPOLY;
        end else begin
          // Narrow the bracket toward t, resample at the midpoint
          lo_d = nlo;
          hi_d = nhi;
          s_d  = SW'(mid[XW:1]);
          st_d = ST_BCHK;
        end
      end
      ST_DPOLY: begin
        acc_d = mul_r;
        ph_d  = ph_q + 2'd1;
        if (ph_q == 2'd1) begin
          ph_d = 2'd0;
          st_d = ST_DCHK;
        end
      end
      ST_DCHK: begin
        qneg_d = err_q[AW-1] ^ dval[AW-1];
        if (adval <= TOL) begin
          lo_d = '0; hi_d = ONE_X; bis_d = 1'b1;
          st_d = ST_BCHK;
        end else if ({2'b00, (err_q[AW-1] ? AW'(-err_q) : AW'(err_q))} >= ad4) begin
          // Quotient at 4.0 or past: saturate it, the clamp settles it anyway
          qm_d = '1;
          st_d = ST_UPD;
        end else begin
          rem_d = RW'(err_q[AW-1] ? AW'(-err_q) : AW'(err_q)) << F;
          dsh_d = RW'(adval) << (QB-1);
          qm_d  = '0;
          cnt_d = CNW'(QB-1);
          st_d  = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem_q >= dsh_q) begin
          rem_d = rem_q - dsh_q;
          qm_d  = {qm_q[QB-2:0], 1'b1};
        end else begin
          qm_d  = {qm_q[QB-2:0], 1'b0};
        end
        dsh_d = dsh_q >> 1;
        cnt_d = cnt_q - CNW'(1);
        if (cnt_q == '0) st_d = ST_UPD;
      end
      ST_UPD: begin
        if (snew[QB+1])                    s_d = '0;
        else if (snew > (QB+2)'(ONE_X))    s_d = SW'(ONE_X);
        else                               s_d = snew[SW-1:0];
        ni_d = ni_q + NW'(1);
        if (ni_q == NLAST) begin
          lo_d = '0; hi_d = ONE_X; bis_d = 1'b1;
          st_d = ST_BCHK;
        end else begin
          st_d = ST_POLY;
        end
      end
      ST_BCHK: begin
        if (span <= TOL_X) ysel_d = 1'b1;
        st_d = ST_POLY;
      end
      ST_OUT: begin
        if (out_ready_i) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q <= ax_d; bx_q <= bx_d; cx_q <= cx_d; ay_q <= ay_d; by_q <= by_d; cy_q <= cy_d;
    a3_q <= a3_d; b2_q <= b2_d;
    t_q <= t_d; lo_q <= lo_d; hi_q <= hi_d; s_q <= s_d;
    acc_q <= acc_d; err_q <= err_d; ph_q <= ph_d;
    ysel_q <= ysel_d; bis_q <= bis_d; qneg_q <= qneg_d; ni_q <= ni_d;
    rem_q <= rem_d; dsh_q <= dsh_d; qm_q <= qm_d; cnt_q <= cnt_d;
    eased_q <= eased_d;
  end

  assign in_ready_o  = (st_q == ST_IDLE);
  assign out_valid_o = (st_q == ST_OUT);
  assign eased_o     = eased_q;

endmodule
